// File: rtl/ebj_pkg.sv
// shared constants, types and codes for the exponential backoff jitter block
// no dependencies; imported by every module of the block
package ebj_pkg;

    // field widths
    localparam int unsigned ACT_W    = 2;
    localparam int unsigned MS_W     = 32;
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned ATT_W    = 6;
    localparam int unsigned JIT_W    = 15;
    localparam int unsigned CFG_IDX_W = 2;

    // serial unit sizes
    localparam int unsigned LCG_IDX_W = $clog2(MS_W);
    localparam int unsigned DIV_W     = 2 * MS_W - FRAC_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

    // action codes carried in tuser
    localparam logic [ACT_W-1:0] ACT_FAIL   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RESEED = 2'd2;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_JFRAC = 2'd2;

    // register reset values
    localparam logic [MS_W-1:0]   BASE_RESET  = 32'd1000;
    localparam logic [MS_W-1:0]   MAX_RESET   = 32'd60000;
    localparam logic [FRAC_W-1:0] JFRAC_RESET = 16'd13107;

    // generator and delay constants
    localparam logic [MS_W-1:0]   LCG_MUL     = 32'd1103515245;
    localparam logic [MS_W-1:0]   LCG_INC     = 32'd12345;
    localparam logic [MS_W-1:0]   RNG_RESET   = 32'h1234_5678;
    localparam logic [JIT_W-1:0]  JIT_SPAN    = 15'h7FFF;
    localparam logic [MS_W-1:0]   MIN_DELAY   = 32'd100;
    localparam logic [ATT_W-1:0]  ATTEMPT_MAX = 6'd63;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GEN,
        ST_MUL_FRAC,
        ST_MUL_BASE,
        ST_DIV,
        ST_SUM,
        ST_CLAMP,
        ST_OUT
    } t_state;

    // sequencer strobes towards the datapath
    typedef struct packed {
        logic s_ready;
        logic gen_start;
        logic mul_start;
        logic mul_sel_frac;
        logic div_start;
        logic out_load;
    } t_ctl;

endpackage

// File: rtl/exponential_backoff_jitter.sv
// top level of the exponential backoff jitter block: sequencer, registers, output stage
// depends on ebj_pkg, ebj_lcg, ebj_base, ebj_mul, ebj_div
//
// usage
//   s_axis carries one command word: tuser is the action (record failure, clear
//   attempts, reseed generator), tdata holds seed_value and now_ms.
//   m_axis returns one word per failure: delay_ms and retry_at_ms.
//   the config channel writes base_delay_ms, max_delay_ms, jitter_fraction by
//   index; it is always ready and must only be used while the block is idle.
// sequence
//   clear and reseed words give no result.
//   a failure word runs the generator step and base doubling side by side, then
//   the two passes of the serial multiplier and the serial divide by 32767, then
//   adds, clamps and loads the output. s_axis_tready is low throughout, so a new
//   word is taken only once the failure has finished.
// reset and stalls
//   reset restores the register defaults, clears the attempt count, loads the
//   generator with its start value and empties the output stage.
//   a result waits in the output register while m_axis_tready is low; new words
//   are still taken, and a following failure holds at its last step until the
//   output register frees up.
module exponential_backoff_jitter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ebj_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ebj_pkg::MS_W-1:0]          i_cfg_data,
    // command words
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [2*ebj_pkg::MS_W-1:0]        s_axis_tdata,  // seed_value, now_ms
    input  logic [ebj_pkg::ACT_W-1:0]         s_axis_tuser,  // action
    // result words
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [2*ebj_pkg::MS_W-1:0]        m_axis_tdata   // delay_ms, retry_at_ms
);
    import ebj_pkg::*;

    t_state              r_state;
    t_state              n_state;
    t_ctl                w_ctl;

    // config registers
    logic [MS_W-1:0]     r_base;
    logic [MS_W-1:0]     r_max;
    logic [FRAC_W-1:0]   r_jfrac;

    // per-item state
    logic [ATT_W-1:0]    r_att;
    logic [ATT_W-1:0]    w_att_inc;
    logic [MS_W-1:0]     r_now;
    logic                r_neg;
    logic [MS_W:0]       r_fin;
    logic [MS_W-1:0]     r_delay;

    // output stage
    logic                r_m_valid;
    logic [2*MS_W-1:0]   r_m_data;

    // unit hookup
    logic                w_in_acc;
    logic [MS_W-1:0]     w_rng;
    logic                w_lcg_busy;
    logic [MS_W-1:0]     w_base;
    logic                w_base_busy;
    logic [MS_W-1:0]     w_mul_a;
    logic [MS_W-1:0]     w_mul_b;
    logic [2*MS_W-1:0]   w_prod;
    logic                w_mul_busy;
    logic [DIV_W-1:0]    w_quot;
    logic                w_div_busy;
    logic                w_out_free;

    // jitter factor 2b - span as sign and magnitude
    logic [JIT_W-1:0]    w_jb;
    logic [JIT_W:0]      w_jb2;
    logic                w_jpos;
    logic [JIT_W:0]      w_jmag;

    logic [MS_W-1:0]     w_q;
    logic [MS_W:0]       w_sum;
    logic [MS_W-1:0]     w_clamp;

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_m_valid || m_axis_tready;
    assign w_att_inc  = (r_att == ATTEMPT_MAX) ? r_att : r_att + 1'b1;

    // config always accepted
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= BASE_RESET;
            r_max   <= MAX_RESET;
            r_jfrac <= JFRAC_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BASE:  r_base  <= i_cfg_data;
                REG_MAX:   r_max   <= i_cfg_data;
                REG_JFRAC: r_jfrac <= i_cfg_data[FRAC_W-1:0];
                default:   ;
            endcase
        end
    end

    // sequencer: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && s_axis_tuser == ACT_FAIL) n_state = ST_GEN;
            end
            ST_GEN: begin
                if (!w_lcg_busy && !w_base_busy) n_state = ST_MUL_FRAC;
            end
            ST_MUL_FRAC: begin
                if (!w_mul_busy) n_state = ST_MUL_BASE;
            end
            ST_MUL_BASE: begin
                if (!w_mul_busy) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (!w_div_busy) n_state = ST_SUM;
            end
            ST_SUM:   n_state = ST_CLAMP;
            ST_CLAMP: n_state = ST_OUT;
            ST_OUT: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // sequencer: strobes
    always_comb begin
        w_ctl = '0;
        case (r_state)
            ST_IDLE: begin
                w_ctl.s_ready   = 1'b1;
                w_ctl.gen_start = w_in_acc && s_axis_tuser == ACT_FAIL;
            end
            ST_GEN: begin
                w_ctl.mul_sel_frac = 1'b1;
                w_ctl.mul_start    = !w_lcg_busy && !w_base_busy;
            end
            ST_MUL_FRAC: w_ctl.mul_start = !w_mul_busy;
            ST_MUL_BASE: w_ctl.div_start = !w_mul_busy;
            ST_OUT:      w_ctl.out_load  = w_out_free;
            default:     ;
        endcase
    end

    assign s_axis_tready = w_ctl.s_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // attempt count and captured time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_att <= '0;
        end else if (w_in_acc) begin
            if (s_axis_tuser == ACT_CLEAR) begin
                r_att <= '0;
            end else if (s_axis_tuser == ACT_FAIL) begin
                r_att <= w_att_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_now <= s_axis_tdata[2*MS_W-1:MS_W];
        end
    end

    ebj_lcg u_lcg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_in_acc && s_axis_tuser == ACT_RESEED),
        .i_seed  (s_axis_tdata[MS_W-1:0]),
        .i_start (w_ctl.gen_start),
        .o_state (w_rng),
        .o_busy  (w_lcg_busy)
    );

    ebj_base u_base (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ctl.gen_start),
        .i_base  (r_base),
        .i_max   (r_max),
        .i_att   (w_att_inc),
        .o_base  (w_base),
        .o_busy  (w_base_busy)
    );

    // b taken from bits 30..16 of the new generator state
    assign w_jb   = w_rng[MS_W-2:MS_W-1-JIT_W];
    assign w_jb2  = {w_jb, 1'b0};
    assign w_jpos = w_jb2 >= {1'b0, JIT_SPAN};
    assign w_jmag = w_jpos ? (w_jb2 - {1'b0, JIT_SPAN}) : ({1'b0, JIT_SPAN} - w_jb2);

    always_ff @(posedge i_clk) begin
        if (w_ctl.mul_start && w_ctl.mul_sel_frac) begin
            r_neg <= !w_jpos;
        end
    end

    // first pass fraction times factor, second pass base times that
    assign w_mul_a = w_ctl.mul_sel_frac ? {{(MS_W-FRAC_W){1'b0}}, r_jfrac} : w_base;
    assign w_mul_b = w_ctl.mul_sel_frac ? {{(MS_W-JIT_W){1'b0}}, w_jmag[JIT_W-1:0]}
                                        : w_prod[MS_W-1:0];

    ebj_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ctl.mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_prod  (w_prod),
        .o_busy  (w_mul_busy)
    );

    // the 65536 part of the divisor is a plain shift
    ebj_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_ctl.div_start),
        .i_dividend (w_prod[DIV_W+FRAC_W-1:FRAC_W]),
        .o_quot     (w_quot),
        .o_busy     (w_div_busy)
    );

    // jitter stays below the base, so the quotient fits one word
    assign w_q = w_quot[MS_W-1:0];

    always_comb begin
        if (r_neg) begin
            w_sum = (w_q > w_base) ? '0 : {1'b0, w_base - w_q};
        end else begin
            w_sum = {1'b0, w_base} + {1'b0, w_q};
        end
    end

    // clamp to max first, floor of 100 wins afterwards
    assign w_clamp = (r_fin > {1'b0, r_max}) ? r_max : r_fin[MS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SUM) begin
            r_fin <= w_sum;
        end
        if (r_state == ST_CLAMP) begin
            r_delay <= (w_clamp < MIN_DELAY) ? MIN_DELAY : w_clamp;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_ctl.out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.out_load) begin
            r_m_data <= {r_now + r_delay, r_delay};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

// File: rtl/ebj_lcg.sv
// bit-serial linear congruential generator, one multiplier bit per cycle
// depends on ebj_pkg
module ebj_lcg (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  logic [ebj_pkg::MS_W-1:0] i_seed,
    input  logic                     i_start,
    output logic [ebj_pkg::MS_W-1:0] o_state,
    output logic                     o_busy
);
    import ebj_pkg::*;

    logic [MS_W-1:0]      r_state;
    logic [MS_W-1:0]      r_x;
    logic [MS_W-1:0]      r_acc;
    logic [LCG_IDX_W-1:0] r_idx;
    logic                 r_busy;
    logic [MS_W-1:0]      w_sum;

    // low word only, so carries past bit 31 drop out
    assign w_sum = r_acc + (LCG_MUL[r_idx] ? r_x : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RNG_RESET;
            r_busy  <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_state <= i_seed;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_x    <= r_state;
            r_acc  <= LCG_INC;
        end else if (r_busy) begin
            r_x   <= r_x << 1;
            r_idx <= r_idx + 1'b1;
            if (r_idx == LCG_IDX_W'(MS_W - 1)) begin
                r_state <= w_sum;
                r_busy  <= 1'b0;
            end else begin
                r_acc <= w_sum;
            end
        end
    end

    assign o_state = r_state;
    assign o_busy  = r_busy;

endmodule

// File: rtl/ebj_base.sv
// base delay unit: doubles the first delay once per cycle for each attempt past the first, up to the clamp
// depends on ebj_pkg
module ebj_base (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [ebj_pkg::MS_W-1:0]  i_base,
    input  logic [ebj_pkg::MS_W-1:0]  i_max,
    input  logic [ebj_pkg::ATT_W-1:0] i_att,
    output logic [ebj_pkg::MS_W-1:0]  o_base,
    output logic                      o_busy
);
    import ebj_pkg::*;

    logic [MS_W-1:0]  r_b;
    logic [ATT_W-1:0] r_cnt;
    logic             r_busy;
    logic             w_stop;
    logic             w_over;

    // a zero base never grows, so it ends the loop as well
    assign w_stop = (r_cnt == '0) || (r_b >= i_max) || (r_b == '0);
    assign w_over = r_b > (i_max >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_b    <= i_base;
            r_cnt  <= i_att - 1'b1;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            if (w_stop) begin
                r_b    <= (r_b > i_max) ? i_max : r_b;
                r_busy <= 1'b0;
            end else if (w_over) begin
                r_b    <= i_max;
                r_busy <= 1'b0;
            end else begin
                r_b   <= r_b << 1;
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_base = r_b;
    assign o_busy = r_busy;

endmodule

// File: rtl/ebj_mul.sv
// shift-add multiplier, 32 by 32 bits, one multiplier bit per cycle
// depends on ebj_pkg
module ebj_mul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ebj_pkg::MS_W-1:0]   i_a,
    input  logic [ebj_pkg::MS_W-1:0]   i_b,
    output logic [2*ebj_pkg::MS_W-1:0] o_prod,
    output logic                       o_busy
);
    import ebj_pkg::*;

    logic [MS_W-1:0]      r_a;
    logic [MS_W-1:0]      r_hi;
    logic [MS_W-1:0]      r_lo;
    logic [LCG_IDX_W-1:0] r_cnt;
    logic                 r_busy;
    logic [MS_W:0]        w_sum;

    assign w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_a    <= i_a;
            r_hi   <= '0;
            r_lo   <= i_b;
            r_cnt  <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            // product shifts right as multiplier bits are used up
            r_hi  <= w_sum[MS_W:1];
            r_lo  <= {w_sum[0], r_lo[MS_W-1:1]};
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LCG_IDX_W'(MS_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_prod = {r_hi, r_lo};
    assign o_busy = r_busy;

endmodule

// File: rtl/ebj_div.sv
// restoring divider by the jitter span, one quotient bit per cycle
// depends on ebj_pkg
module ebj_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ebj_pkg::DIV_W-1:0]  i_dividend,
    output logic [ebj_pkg::DIV_W-1:0]  o_quot,
    output logic                       o_busy
);
    import ebj_pkg::*;

    logic [DIV_W-1:0]     r_q;
    logic [JIT_W-1:0]     r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic [JIT_W:0]       w_trial;
    logic [JIT_W:0]       w_diff;
    logic                 w_ge;

    assign w_trial = {r_rem, r_q[DIV_W-1]};
    assign w_ge    = w_trial >= {1'b0, JIT_SPAN};
    assign w_diff  = w_trial - {1'b0, JIT_SPAN};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_q    <= i_dividend;
            r_rem  <= '0;
            r_cnt  <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            // remainder stays below the span, so 15 bits hold it
            r_rem <= w_ge ? w_diff[JIT_W-1:0] : w_trial[JIT_W-1:0];
            r_q   <= {r_q[DIV_W-2:0], w_ge};
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_quot = r_q;
    assign o_busy = r_busy;

endmodule

// File: rtl/ebj_chk.sv
// port-level checker for the exponential backoff jitter block, with its bind
// depends on ebj_pkg and on the ports of exponential_backoff_jitter
module ebj_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_valid,
    input logic                          i_s_ready,
    input logic [ebj_pkg::ACT_W-1:0]     i_s_user,
    input logic                          i_m_valid,
    input logic                          i_m_ready,
    input logic [2*ebj_pkg::MS_W-1:0]    i_m_data
);
    import ebj_pkg::*;

    // output stage empties on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_valid)
        else $error("result word present after reset");

    // every delay honours the 100 ms floor
    a_delay_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_valid |-> i_m_data[MS_W-1:0] >= MIN_DELAY)
        else $error("delay below floor");

    // a failure word takes input ready low once it is accepted
    a_fail_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_s_valid && i_s_ready && i_s_user == ACT_FAIL |=> !i_s_ready)
        else $error("input taken while failure in progress");

    // clear, reseed and unused words give no result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && !i_m_valid && i_s_valid && i_s_ready && i_s_user != ACT_FAIL
        |=> !i_m_valid)
        else $error("result word without failure");

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_m_valid && !i_m_ready |=> i_m_valid && $stable(i_m_data))
        else $error("stalled result word changed");

endmodule

bind exponential_backoff_jitter ebj_chk u_ebj_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_valid (s_axis_tvalid),
    .i_s_ready (s_axis_tready),
    .i_s_user  (s_axis_tuser),
    .i_m_valid (m_axis_tvalid),
    .i_m_ready (m_axis_tready),
    .i_m_data  (m_axis_tdata)
);

// File: tb/sv/ebj_tb_pkg.sv
// scoreboard for the exponential backoff jitter testbench: result prediction and checking
// depends on ebj_pkg for widths, action codes, register indexes and constants
package ebj_tb_pkg;
    import ebj_pkg::*;

    typedef struct packed {
        logic [MS_W-1:0] retry_at_ms;
        logic [MS_W-1:0] delay_ms;
    } t_retry;

    // 32767 * 65536, the jitter scale
    localparam logic [2*MS_W-1:0] JIT_DIVISOR = {33'd0, JIT_SPAN, 16'd0};
    localparam int unsigned SHOWN_MISMATCHES = 10;

    class backoff_scoreboard;
        logic [MS_W-1:0]   base_ms;
        logic [MS_W-1:0]   cap_ms;
        logic [FRAC_W-1:0] jitter_frac;
        logic [ATT_W-1:0]  attempts;
        logic [MS_W-1:0]   lcg;
        t_retry            due_retries[$];
        int unsigned       n_retry = 0;
        int unsigned       n_ceiling = 0;
        int unsigned       n_clear = 0;
        int unsigned       n_reseed = 0;
        int unsigned       n_spare = 0;
        int unsigned       n_checked = 0;
        int unsigned       n_mismatch = 0;
        int unsigned       n_regs = 0;

        function new();
            base_ms     = BASE_RESET;
            cap_ms      = MAX_RESET;
            jitter_frac = JFRAC_RESET;
            attempts    = '0;
            lcg         = RNG_RESET;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [MS_W-1:0] data);
            n_regs++;
            case (index)
                REG_BASE:  base_ms = data;
                REG_MAX:   cap_ms = data;
                REG_JFRAC: jitter_frac = data[FRAC_W-1:0];
                default: ;
            endcase
        endfunction

        // bump the attempt count, step the generator and form the clamped delay
        function t_retry next_retry(logic [MS_W-1:0] now_ms);
            logic [2*MS_W-1:0] grown;
            logic [2*MS_W-1:0] cap;
            logic [2*MS_W-1:0] spread;
            logic [2*MS_W-1:0] total;
            logic [JIT_W-1:0]  draw;
            logic [JIT_W:0]    twice;
            int unsigned       k;
            t_retry            r;
            if (attempts == ATTEMPT_MAX) begin
                n_ceiling++;
            end else begin
                attempts++;
            end
            grown = base_ms;
            cap   = cap_ms;
            k     = 1;
            // doubling stops at the cap; past half the cap it jumps straight to it
            while (k < attempts && grown < cap) begin
                if (grown > cap / 2) begin
                    grown = cap;
                end else begin
                    grown = grown << 1;
                end
                k++;
            end
            if (grown > cap) begin
                grown = cap;
            end
            lcg   = lcg * LCG_MUL + LCG_INC;
            draw  = lcg[30:16];
            twice = {draw, 1'b0};
            if (twice >= JIT_SPAN) begin
                spread = twice - JIT_SPAN;
                spread = (grown * jitter_frac * spread) / JIT_DIVISOR;
                total  = grown + spread;
            end else begin
                spread = JIT_SPAN - twice;
                spread = (grown * jitter_frac * spread) / JIT_DIVISOR;
                total  = (spread > grown) ? '0 : grown - spread;
            end
            if (total > cap) begin
                total = cap;
            end
            if (total < MIN_DELAY) begin
                total = MIN_DELAY;
            end
            r.delay_ms    = total[MS_W-1:0];
            r.retry_at_ms = now_ms + total[MS_W-1:0];
            return r;
        endfunction

        function void note_word(logic [ACT_W-1:0] action, logic [MS_W-1:0] seed_value,
                                logic [MS_W-1:0] now_ms);
            case (action)
                ACT_FAIL: begin
                    due_retries.push_back(next_retry(now_ms));
                    n_retry++;
                end
                ACT_CLEAR: begin
                    attempts = '0;
                    n_clear++;
                end
                ACT_RESEED: begin
                    lcg = seed_value;
                    n_reseed++;
                end
                default: n_spare++;
            endcase
        endfunction

        function void check_word(logic [MS_W-1:0] delay_ms, logic [MS_W-1:0] retry_at_ms);
            t_retry want;
            if (due_retries.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= SHOWN_MISMATCHES) begin
                    $display("unexpected result word: delay_ms %0d retry_at_ms %0d",
                             delay_ms, retry_at_ms);
                end
                return;
            end
            want = due_retries.pop_front();
            n_checked++;
            if (delay_ms !== want.delay_ms || retry_at_ms !== want.retry_at_ms) begin
                n_mismatch++;
                if (n_mismatch <= SHOWN_MISMATCHES) begin
                    $display("result %0d: delay_ms expected %0d got %0d, %s",
                             n_checked, want.delay_ms, delay_ms,
                             $sformatf("retry_at_ms expected %0d got %0d",
                                       want.retry_at_ms, retry_at_ms));
                end
            end
        endfunction

        function int unsigned errors();
            return n_mismatch + due_retries.size();
        endfunction
    endclass

endpackage

// File: tb/sv/tb_exponential_backoff_jitter.sv
// top-level testbench for the exponential backoff jitter block
// depends on ebj_pkg, ebj_tb_pkg and the block's rtl; drives command and config words
module tb_exponential_backoff_jitter;
    import ebj_pkg::*;
    import ebj_tb_pkg::*;

    localparam int unsigned HALF_PERIOD    = 4;
    localparam int unsigned RESET_CYCLES   = 6;
    // leave ample margin for a retry request to finish before register writes
    localparam int unsigned SETTLE_CYCLES  = 200;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned PHASE_ITEMS    = 85;
    localparam int unsigned N_PHASES       = 9;
    // codes the block has no use for
    localparam logic [ACT_W-1:0]     ACT_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [MS_W-1:0]        i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [2*MS_W-1:0]      s_axis_tdata = '0;   // seed_value, now_ms
    logic [ACT_W-1:0]       s_axis_tuser = '0;   // action
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [2*MS_W-1:0]      m_axis_tdata;        // delay_ms, retry_at_ms

    backoff_scoreboard sb = new();
    bit                calm = 1'b0;              // final phase: no idling on either side
    int unsigned       quiet_cycles = 0;

    exponential_backoff_jitter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // present one command word and hold it until taken; tvalid stays high afterwards
    task automatic send_word(input logic [ACT_W-1:0] action, input logic [MS_W-1:0] seed_value,
                             input logic [MS_W-1:0] now_ms);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= action;
        s_axis_tdata  <= {now_ms, seed_value};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(action, seed_value, now_ms);
    endtask

    // one register write; i_cfg_valid is lowered by the caller after the last one
    task automatic cfg_word(input logic [CFG_IDX_W-1:0] index, input logic [MS_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(index, data);
    endtask

    // wait for every outstanding result, then let the sequencer settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.due_retries.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // solve for the seed whose next generator state gives the wanted jitter sample
    function automatic logic [MS_W-1:0] seed_for_draw(input logic [JIT_W-1:0] draw);
        logic [MS_W-1:0] inv;
        inv = LCG_MUL;
        // newton steps for the multiplicative inverse modulo 2^32
        repeat (5) inv = inv * (32'd2 - LCG_MUL * inv);
        return ({1'b0, draw, 16'h0000} - LCG_INC) * inv;
    endfunction

    // result side: compare every word taken against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_word(m_axis_tdata[MS_W-1:0], m_axis_tdata[2*MS_W-1:MS_W]);
        end
    end

    // backpressure in random bursts of random length, none once calm
    initial begin : sink_pacing
        logic        level;
        int unsigned span;
        forever begin
            if (calm) begin
                level = 1'b1;
                span  = 1;
            end else begin
                level = ($urandom_range(0, 2) != 0);
                span  = level ? $urandom_range(1, 30) : $urandom_range(1, 14);
            end
            m_axis_tready <= level;
            repeat (span) @(posedge i_clk);
        end
    end

    // watchdog: any handshake resets the count of quiet cycles
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        int unsigned          phase;
        int unsigned          clear_pct;
        int unsigned          gap_pct;
        int unsigned          sent;
        int unsigned          pick;
        logic [MS_W-1:0]      base_ms;
        logic [MS_W-1:0]      cap_ms;
        logic [MS_W-1:0]      frac_word;
        logic [MS_W-1:0]      seed_value;
        logic [ACT_W-1:0]     action;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words under the reset register values
        send_word(ACT_FAIL, $urandom, 32'h0000_0000);
        send_word(ACT_FAIL, $urandom, 32'hFFFF_FFFF);       // retry time wraps
        send_word(ACT_FAIL, $urandom, 32'hFFFF_FF00);
        send_word(ACT_CLEAR, $urandom, $urandom);
        // largest upward jitter, largest downward, and both sides of zero
        send_word(ACT_RESEED, seed_for_draw(15'h7FFF), $urandom);
        send_word(ACT_FAIL, $urandom, $urandom);
        send_word(ACT_RESEED, seed_for_draw(15'h0000), $urandom);
        send_word(ACT_FAIL, $urandom, $urandom);
        send_word(ACT_RESEED, seed_for_draw(15'h3FFF), $urandom);
        send_word(ACT_FAIL, $urandom, $urandom);
        send_word(ACT_RESEED, seed_for_draw(15'h4000), $urandom);
        send_word(ACT_FAIL, $urandom, $urandom);
        send_word(ACT_RESEED, 32'h0000_0000, $urandom);
        send_word(ACT_FAIL, $urandom, $urandom);
        send_word(ACT_RESEED, 32'hFFFF_FFFF, $urandom);
        send_word(ACT_FAIL, $urandom, $urandom);
        send_word(ACT_SPARE, $urandom, $urandom);            // ignored, no result
        // keep failing until doubling runs into the cap
        repeat (7) send_word(ACT_FAIL, $urandom, $urandom);
        send_word(ACT_CLEAR, $urandom, $urandom);
        send_word(ACT_FAIL, $urandom, $urandom);
        drain();

        for (phase = 0; phase < N_PHASES; phase++) begin
            gap_pct   = (phase % 2 == 0) ? 35 : 10;
            clear_pct = 10;
            case (phase)
                0: begin
                    // zero base and zero cap: the floor of 100 wins
                    base_ms   = '0;
                    cap_ms    = '0;
                    frac_word = '0;
                end
                1: begin
                    base_ms   = '1;
                    cap_ms    = '1;
                    frac_word = $urandom | 32'h0000_FFFF;
                    clear_pct = 5;
                end
                2: begin
                    // no clears, so the attempt count climbs to its ceiling
                    base_ms   = 32'd1;
                    cap_ms    = '1;
                    frac_word = 32'h0000_FFFF;
                    clear_pct = 0;
                end
                3: begin
                    // cap below the floor
                    base_ms   = 32'd50;
                    cap_ms    = 32'd99;
                    frac_word = 32'd40000;
                end
                4: begin
                    base_ms   = 32'd7;
                    cap_ms    = MIN_DELAY;
                    frac_word = $urandom;
                end
                N_PHASES - 1: begin
                    // back to the reset values, with no idling at all
                    base_ms   = BASE_RESET;
                    cap_ms    = MAX_RESET;
                    frac_word = JFRAC_RESET;
                    calm      = 1'b1;
                end
                default: begin
                    base_ms   = $urandom_range(0, 1) ? $urandom : $urandom_range(1, 5000);
                    cap_ms    = $urandom_range(0, 1) ? $urandom : $urandom_range(100, 1000000);
                    frac_word = $urandom;
                    clear_pct = $urandom_range(3, 15);
                end
            endcase
            cfg_word(REG_BASE, base_ms);
            cfg_word(REG_MAX, cap_ms);
            cfg_word(REG_JFRAC, frac_word);
            cfg_word(REG_SPARE, $urandom);                   // must change nothing
            i_cfg_valid <= 1'b0;

            // mostly retry requests, with clears, reseeds and unused codes mixed in
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < clear_pct) begin
                    action = ACT_CLEAR;
                end else if (pick < clear_pct + 8) begin
                    action = ACT_RESEED;
                end else if (pick < clear_pct + 12) begin
                    action = ACT_SPARE;
                end else begin
                    action = ACT_FAIL;
                end
                seed_value = ($urandom_range(0, 9) == 0) ? '0 : $urandom;
                if (!calm && $urandom_range(0, 99) < gap_pct) begin
                    s_axis_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 14)) @(posedge i_clk);
                end
                send_word(action, seed_value, $urandom);
                if (action != ACT_SPARE) begin
                    sent++;
                end
            end
            drain();
        end

        $display("covered %0d retry requests (%0d at the attempt ceiling), %0d clears, %s",
                 sb.n_retry, sb.n_ceiling, sb.n_clear,
                 $sformatf("%0d reseeds, %0d unused actions", sb.n_reseed, sb.n_spare));
        $display("%0d result words compared over %0d register settings, %0d mismatches",
                 sb.n_checked, N_PHASES + 1, sb.n_mismatch);
        if (sb.errors() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
